// ===== rtl/ray_rect_intersect_unit_macros.svh =====
// assertion macros for the ray/rectangle intersection block
// used by the checker file; needs nothing else
`ifndef RAY_RECT_INTERSECT_UNIT_MACROS_SVH
`define RAY_RECT_INTERSECT_UNIT_MACROS_SVH

// same-cycle implication
`define RRI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RRI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rri_pkg.sv =====
// shared types and constants of the ray/rectangle intersection block
// no dependencies
package rri_pkg;

    // u and v output width (Q0.16)
    localparam int UV_BITS = 16;

    // configuration register index
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_MIN = 2'd0,
        CFG_X_MAX = 2'd1,
        CFG_Z_MIN = 2'd2,
        CFG_Z_MAX = 2'd3
    } rri_cfg_idx_t;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    // per-ray classification from the front end
    typedef struct packed {
        logic dy_zero;
        logic dy_neg;
        logic t_neg;
        logic x_neg;
        logic z_neg;
    } rri_flags_t;

endpackage

// ===== rtl/rri_stream_if.sv =====
// ray request and result channels with valid/ready handshake
// depends on rri_pkg
interface rri_ray_if #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] origin_x;
    logic signed [COORD_WIDTH-1:0] origin_y;
    logic signed [COORD_WIDTH-1:0] origin_z;
    logic signed [COORD_WIDTH-1:0] dir_x;
    logic signed [COORD_WIDTH-1:0] dir_y;
    logic signed [COORD_WIDTH-1:0] dir_z;
    logic        [COORD_WIDTH-2:0] t_lower;
    logic        [COORD_WIDTH-2:0] t_upper;

    modport source (output valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    t_lower, t_upper, input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z, dir_x, dir_y, dir_z,
                    t_lower, t_upper, output ready);
endinterface

interface rri_hit_if import rri_pkg::*; #(parameter int COORD_WIDTH = 32);
    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic signed [COORD_WIDTH-1:0] t_hit;
    logic        [UV_BITS-1:0]     u_coord;
    logic        [UV_BITS-1:0]     v_coord;
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
    logic signed [COORD_WIDTH-1:0] point_z;
    logic                          front_face;

    modport source (output valid, hit, t_hit, u_coord, v_coord, point_x, point_y, point_z,
                    front_face, input ready);
    modport sink   (input valid, hit, t_hit, u_coord, v_coord, point_x, point_y, point_z,
                    front_face, output ready);
endinterface

// ===== rtl/rri_div_pipe.sv =====
// pipelined restoring divider, one quotient bit per stage, several lanes
// carries a sideband word alongside; no package use
module rri_div_pipe #(
    parameter int LANES = 1,
    parameter int N_W   = 8,
    parameter int D_W   = 8,
    parameter int SB_W  = 1
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        in_valid,
    input  logic [LANES-1:0][N_W-1:0]   in_num,
    input  logic [LANES-1:0][D_W-1:0]   in_den,
    input  logic [SB_W-1:0]             in_sb,
    output logic                        out_valid,
    output logic [LANES-1:0][N_W-1:0]   out_quo,
    output logic [SB_W-1:0]             out_sb
);

    logic                 valid_reg [N_W];
    logic [SB_W-1:0]      sb_reg    [N_W];
    logic [D_W-1:0]       rem_reg   [N_W][LANES];
    logic [N_W-1:0]       quo_reg   [N_W][LANES];
    logic [D_W-1:0]       den_reg   [N_W][LANES];

    for (genvar s = 0; s < N_W; s++)
    begin : g_stage
        logic [D_W-1:0] rem_next [LANES];
        logic [N_W-1:0] quo_next [LANES];
        logic [D_W-1:0] den_next [LANES];

        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            logic [D_W-1:0] rem_prev;
            logic [N_W-1:0] quo_prev;
            logic [D_W:0]   trial;
            logic [D_W:0]   diff;
            logic           ge;

            // previous partial remainder, numerator/quotient word and divisor
            if (s == 0)
            begin : g_first
                assign rem_prev    = '0;
                assign quo_prev    = in_num[l];
                assign den_next[l] = in_den[l];
            end
            else
            begin : g_rest
                assign rem_prev    = rem_reg[s-1][l];
                assign quo_prev    = quo_reg[s-1][l];
                assign den_next[l] = den_reg[s-1][l];
            end

            // one compare-subtract step
            assign trial       = {rem_prev, quo_prev[N_W-1]};
            assign diff        = trial - {1'b0, den_next[l]};
            assign ge          = (trial >= {1'b0, den_next[l]});
            assign rem_next[l] = ge ? diff[D_W-1:0] : trial[D_W-1:0];
            assign quo_next[l] = {quo_prev[N_W-2:0], ge};
        end

        // stage valid
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[s] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[s] <= (s == 0) ? in_valid : valid_reg[(s == 0) ? 0 : s-1];
            end
        end

        // stage payload
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sb_reg[s] <= (s == 0) ? in_sb : sb_reg[(s == 0) ? 0 : s-1];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[s][l] <= rem_next[l];
                    quo_reg[s][l] <= quo_next[l];
                    den_reg[s][l] <= den_next[l];
                end
            end
        end
    end

    // last stage drives the outputs
    assign out_valid = valid_reg[N_W-1];
    assign out_sb    = sb_reg[N_W-1];
    for (genvar l = 0; l < LANES; l++)
    begin : g_out
        assign out_quo[l] = quo_reg[N_W-1][l];
    end

endmodule

// ===== rtl/rri_queue.sv =====
// two-entry queue between the front and back ends
// depends on rri_pkg
module rri_queue import rri_pkg::*; #(
    parameter int DATA_W = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    logic [DATA_W-1:0]      data_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   push;
    logic                   pop;

    assign in_ready  = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = data_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

// ===== rtl/rri_front.sv =====
// front end: accepts rays, forms products and divider operands, classifies signs
// depends on rri_pkg and rri_ray_if
module rri_front import rri_pkg::*; #(
    parameter int W     = 32,
    parameter int F     = 16,
    parameter int NUM_W = 63
) (
    input  logic                 clk,
    input  logic                 rst_n,
    rri_ray_if.sink              ray,
    output logic                 q_valid,
    input  logic                 q_ready,
    output rri_flags_t           flags,
    output logic [W-1:0]         dy_mag,
    output logic [NUM_W-1:0]     num_t,
    output logic [NUM_W-1:0]     num_x,
    output logic [NUM_W-1:0]     num_z,
    output logic [W-1:0]         ox,
    output logic [W-1:0]         oz,
    output logic [W-2:0]         tl,
    output logic [W-2:0]         tu
);

    logic en;

    // input stage
    logic         s0_valid_reg;
    logic [W-1:0] s0_ox_reg, s0_oy_reg, s0_oz_reg;
    logic [W-1:0] s0_dx_reg, s0_dy_reg, s0_dz_reg;
    logic [W-2:0] s0_tl_reg, s0_tu_reg;

    // product stage
    logic         s1_valid_reg;
    logic [W:0]   s1_noy_reg;
    logic [2*W:0] s1_px_reg, s1_pz_reg;
    logic [W-1:0] s1_ox_reg, s1_oz_reg, s1_dy_reg;
    logic [W-2:0] s1_tl_reg, s1_tu_reg;
    logic [W:0]   s1_noy_next;
    logic [2*W:0] s1_px_next, s1_pz_next;

    // magnitude stage
    logic         s2_valid_reg;
    rri_flags_t   s2_flags_reg;
    rri_flags_t   s2_flags_next;
    logic [W-1:0] s2_dy_reg;
    logic [NUM_W-1:0] s2_nt_reg, s2_nx_reg, s2_nz_reg;
    logic [W-1:0] s2_ox_reg, s2_oz_reg;
    logic [W-2:0] s2_tl_reg, s2_tu_reg;
    logic [W:0]   noy_abs, dy_ext, dy_abs;
    logic [2*W:0] px_abs, pz_abs;
    logic [W+F-1:0] nt_shift;

    assign en        = !s2_valid_reg || q_ready;
    assign ray.ready = en;

    // negated origin y and the two cross products
    assign s1_noy_next = ~{s0_oy_reg[W-1], s0_oy_reg} + 1'b1;
    assign s1_px_next  = $signed(s1_noy_next) * $signed(s0_dx_reg);
    assign s1_pz_next  = $signed(s1_noy_next) * $signed(s0_dz_reg);

    // magnitudes and quotient signs
    assign noy_abs  = s1_noy_reg[W] ? (~s1_noy_reg + 1'b1) : s1_noy_reg;
    assign dy_ext   = {s1_dy_reg[W-1], s1_dy_reg};
    assign dy_abs   = dy_ext[W] ? (~dy_ext + 1'b1) : dy_ext;
    assign px_abs   = s1_px_reg[2*W] ? (~s1_px_reg + 1'b1) : s1_px_reg;
    assign pz_abs   = s1_pz_reg[2*W] ? (~s1_pz_reg + 1'b1) : s1_pz_reg;
    assign nt_shift = {noy_abs[W-1:0], {F{1'b0}}};

    always_comb
    begin
        s2_flags_next.dy_zero = (s1_dy_reg == '0);
        s2_flags_next.dy_neg  = s1_dy_reg[W-1];
        s2_flags_next.t_neg   = s1_noy_reg[W] ^ s1_dy_reg[W-1];
        s2_flags_next.x_neg   = s1_px_reg[2*W] ^ s1_dy_reg[W-1];
        s2_flags_next.z_neg   = s1_pz_reg[2*W] ^ s1_dy_reg[W-1];
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            s0_valid_reg <= ray.valid;
            s1_valid_reg <= s0_valid_reg;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s0_ox_reg <= ray.origin_x;
            s0_oy_reg <= ray.origin_y;
            s0_oz_reg <= ray.origin_z;
            s0_dx_reg <= ray.dir_x;
            s0_dy_reg <= ray.dir_y;
            s0_dz_reg <= ray.dir_z;
            s0_tl_reg <= ray.t_lower;
            s0_tu_reg <= ray.t_upper;

            s1_noy_reg <= s1_noy_next;
            s1_px_reg  <= s1_px_next;
            s1_pz_reg  <= s1_pz_next;
            s1_ox_reg  <= s0_ox_reg;
            s1_oz_reg  <= s0_oz_reg;
            s1_dy_reg  <= s0_dy_reg;
            s1_tl_reg  <= s0_tl_reg;
            s1_tu_reg  <= s0_tu_reg;

            s2_flags_reg <= s2_flags_next;
            s2_dy_reg    <= dy_abs[W-1:0];
            s2_nt_reg    <= NUM_W'(nt_shift);
            s2_nx_reg    <= NUM_W'(px_abs[2*W-2:0]);
            s2_nz_reg    <= NUM_W'(pz_abs[2*W-2:0]);
            s2_ox_reg    <= s1_ox_reg;
            s2_oz_reg    <= s1_oz_reg;
            s2_tl_reg    <= s1_tl_reg;
            s2_tu_reg    <= s1_tu_reg;
        end
    end

    assign q_valid = s2_valid_reg;
    assign flags   = s2_flags_reg;
    assign dy_mag  = s2_dy_reg;
    assign num_t   = s2_nt_reg;
    assign num_x   = s2_nx_reg;
    assign num_z   = s2_nz_reg;
    assign ox      = s2_ox_reg;
    assign oz      = s2_oz_reg;
    assign tl      = s2_tl_reg;
    assign tu      = s2_tu_reg;

endmodule

// ===== rtl/rri_back.sv =====
// back end: divides by dir_y, tests interval and rectangle, normalizes u and v
// depends on rri_pkg, rri_hit_if and rri_div_pipe
module rri_back import rri_pkg::*; #(
    parameter int W     = 32,
    parameter int NUM_W = 63
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  rri_flags_t       flags,
    input  logic [W-1:0]     dy_mag,
    input  logic [NUM_W-1:0] num_t,
    input  logic [NUM_W-1:0] num_x,
    input  logic [NUM_W-1:0] num_z,
    input  logic [W-1:0]     ox,
    input  logic [W-1:0]     oz,
    input  logic [W-2:0]     tl,
    input  logic [W-2:0]     tu,
    input  logic [W-1:0]     x_min,
    input  logic [W-1:0]     x_max,
    input  logic [W-1:0]     z_min,
    input  logic [W-1:0]     z_max,
    rri_hit_if.source        result
);

    localparam int FL_W  = $bits(rri_flags_t);
    localparam int SBA_W = FL_W + 2*W + 2*(W-1);
    localparam int XW    = NUM_W + 2;
    localparam int NB_W  = W + UV_BITS;
    localparam int SBB_W = 4 + 3*W;

    logic en;

    // plane crossing division
    logic                        a_valid;
    logic [2:0][NUM_W-1:0]       a_quo;
    logic [SBA_W-1:0]            a_sb;
    rri_flags_t                  a_flags;
    logic [W-1:0]                a_ox, a_oz;
    logic [W-2:0]                a_tl, a_tu;

    // signed results
    logic             c1_valid_reg;
    rri_flags_t       c1_flags_reg;
    logic [NUM_W:0]   c1_t_reg;
    logic [XW-1:0]    c1_x_reg, c1_z_reg;
    logic [W-2:0]     c1_tl_reg, c1_tu_reg;
    logic [NUM_W:0]   qt_ext, qx_ext, qz_ext;
    logic [NUM_W:0]   t_next, offx, offz;
    logic [XW-1:0]    x_next, z_next;

    // classification
    logic             c2_valid_reg;
    logic             c2_hit_reg, c2_ff_reg, c2_okx_reg, c2_okz_reg;
    logic [W-1:0]     c2_thit_reg, c2_xw_reg, c2_zw_reg;
    logic [W-1:0]     c2_diffx_reg, c2_diffz_reg, c2_denx_reg, c2_denz_reg;
    logic [NUM_W:0]   tl_ext, tu_ext, t_max_e, t_min_e;
    logic [XW-1:0]    xmin_e, xmax_e, zmin_e, zmax_e, xd, zd;
    logic [W:0]       denx, denz;
    logic             t_ok, in_rect, hit_next;
    logic [W-1:0]     thit_next;

    // normalization division
    logic                        b_valid;
    logic [1:0][NB_W-1:0]        b_quo;
    logic [SBB_W-1:0]            b_sb;
    logic                        b_hit, b_ff, b_okx, b_okz;
    logic [W-1:0]                b_thit, b_xw, b_zw;
    logic [UV_BITS-1:0]          u_sat, v_sat;

    // output register
    logic                 out_valid_reg;
    logic                 out_hit_reg, out_ff_reg;
    logic [W-1:0]         out_thit_reg, out_px_reg, out_pz_reg;
    logic [UV_BITS-1:0]   out_u_reg, out_v_reg;

    assign en      = !out_valid_reg || result.ready;
    assign q_ready = en;

    rri_div_pipe #(
        .LANES (3),
        .N_W   (NUM_W),
        .D_W   (W),
        .SB_W  (SBA_W)
    ) u_div_plane (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (q_valid),
        .in_num    ({num_z, num_x, num_t}),
        .in_den    ({dy_mag, dy_mag, dy_mag}),
        .in_sb     ({flags, ox, oz, tl, tu}),
        .out_valid (a_valid),
        .out_quo   (a_quo),
        .out_sb    (a_sb)
    );

    assign {a_flags, a_ox, a_oz, a_tl, a_tu} = a_sb;

    // apply quotient signs, add origin offsets
    assign qt_ext = {1'b0, a_quo[0]};
    assign qx_ext = {1'b0, a_quo[1]};
    assign qz_ext = {1'b0, a_quo[2]};
    assign t_next = a_flags.t_neg ? (~qt_ext + 1'b1) : qt_ext;
    assign offx   = a_flags.x_neg ? (~qx_ext + 1'b1) : qx_ext;
    assign offz   = a_flags.z_neg ? (~qz_ext + 1'b1) : qz_ext;
    assign x_next = {{(XW-W){a_ox[W-1]}}, a_ox} + {offx[NUM_W], offx};
    assign z_next = {{(XW-W){a_oz[W-1]}}, a_oz} + {offz[NUM_W], offz};

    // interval test, rectangle test, saturation and extents
    assign tl_ext  = {{(NUM_W-W+2){1'b0}}, c1_tl_reg};
    assign tu_ext  = {{(NUM_W-W+2){1'b0}}, c1_tu_reg};
    assign t_max_e = {{(NUM_W-W+2){1'b0}}, {(W-1){1'b1}}};
    assign t_min_e = {{(NUM_W-W+2){1'b1}}, {(W-1){1'b0}}};
    assign xmin_e  = {{(XW-W){x_min[W-1]}}, x_min};
    assign xmax_e  = {{(XW-W){x_max[W-1]}}, x_max};
    assign zmin_e  = {{(XW-W){z_min[W-1]}}, z_min};
    assign zmax_e  = {{(XW-W){z_max[W-1]}}, z_max};

    assign t_ok = ($signed(c1_t_reg) >= $signed(tl_ext))
               && ((&c1_tu_reg) || ($signed(c1_t_reg) <= $signed(tu_ext)));
    assign in_rect = ($signed(c1_x_reg) >= $signed(xmin_e))
                  && ($signed(c1_x_reg) <= $signed(xmax_e))
                  && ($signed(c1_z_reg) >= $signed(zmin_e))
                  && ($signed(c1_z_reg) <= $signed(zmax_e));
    assign hit_next = !c1_flags_reg.dy_zero && t_ok && in_rect;

    always_comb
    begin
        priority if ($signed(c1_t_reg) > $signed(t_max_e))
        begin
            thit_next = {1'b0, {(W-1){1'b1}}};
        end
        else if ($signed(c1_t_reg) < $signed(t_min_e))
        begin
            thit_next = {1'b1, {(W-1){1'b0}}};
        end
        else
        begin
            thit_next = c1_t_reg[W-1:0];
        end
    end

    assign xd   = c1_x_reg - xmin_e;
    assign zd   = c1_z_reg - zmin_e;
    assign denx = {x_max[W-1], x_max} - {x_min[W-1], x_min};
    assign denz = {z_max[W-1], z_max} - {z_min[W-1], z_min};

    rri_div_pipe #(
        .LANES (2),
        .N_W   (NB_W),
        .D_W   (W),
        .SB_W  (SBB_W)
    ) u_div_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c2_valid_reg),
        .in_num    ({{c2_diffz_reg, {UV_BITS{1'b0}}}, {c2_diffx_reg, {UV_BITS{1'b0}}}}),
        .in_den    ({c2_denz_reg, c2_denx_reg}),
        .in_sb     ({c2_hit_reg, c2_ff_reg, c2_okx_reg, c2_okz_reg,
                     c2_thit_reg, c2_xw_reg, c2_zw_reg}),
        .out_valid (b_valid),
        .out_quo   (b_quo),
        .out_sb    (b_sb)
    );

    assign {b_hit, b_ff, b_okx, b_okz, b_thit, b_xw, b_zw} = b_sb;

    // saturate u and v at all ones
    assign u_sat = (|b_quo[0][NB_W-1:UV_BITS]) ? '1 : b_quo[0][UV_BITS-1:0];
    assign v_sat = (|b_quo[1][NB_W-1:UV_BITS]) ? '1 : b_quo[1][UV_BITS-1:0];

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_valid_reg  <= 1'b0;
            c2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c1_valid_reg  <= a_valid;
            c2_valid_reg  <= c1_valid_reg;
            out_valid_reg <= b_valid;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_flags_reg <= a_flags;
            c1_t_reg     <= t_next;
            c1_x_reg     <= x_next;
            c1_z_reg     <= z_next;
            c1_tl_reg    <= a_tl;
            c1_tu_reg    <= a_tu;

            c2_hit_reg   <= hit_next;
            c2_ff_reg    <= c1_flags_reg.dy_neg;
            c2_okx_reg   <= !denx[W] && (denx != '0);
            c2_okz_reg   <= !denz[W] && (denz != '0);
            c2_thit_reg  <= thit_next;
            c2_xw_reg    <= c1_x_reg[W-1:0];
            c2_zw_reg    <= c1_z_reg[W-1:0];
            c2_diffx_reg <= xd[W-1:0];
            c2_diffz_reg <= zd[W-1:0];
            c2_denx_reg  <= denx[W-1:0];
            c2_denz_reg  <= denz[W-1:0];

            // a miss clears every field
            out_hit_reg  <= b_hit;
            out_ff_reg   <= b_hit && b_ff;
            out_thit_reg <= b_hit ? b_thit : '0;
            out_px_reg   <= b_hit ? b_xw : '0;
            out_pz_reg   <= b_hit ? b_zw : '0;
            out_u_reg    <= (b_hit && b_okx) ? u_sat : '0;
            out_v_reg    <= (b_hit && b_okz) ? v_sat : '0;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.hit        = out_hit_reg;
    assign result.t_hit      = out_thit_reg;
    assign result.u_coord    = out_u_reg;
    assign result.v_coord    = out_v_reg;
    assign result.point_x    = out_px_reg;
    assign result.point_y    = '0;
    assign result.point_z    = out_pz_reg;
    assign result.front_face = out_ff_reg;

endmodule

// ===== rtl/ray_rect_intersect_unit.sv =====
// Path through the block: front stages, queue, max(2*COORD_WIDTH-1, COORD_WIDTH+FRAC_BITS)
// plane divider stages, test stages, (COORD_WIDTH+16) normalize stages and the output
// register; the dividers resolve one quotient bit per stage.
// Throughput: one ray per cycle unless result.ready stalls it; every stage is pipelined.
// Reset: all valid bits clear; rectangle registers return to x and z in [-1.0, +1.0].
// Depends on rri_pkg, rri_stream_if, rri_front, rri_queue, rri_back.
module ray_rect_intersect_unit import rri_pkg::*; #(
    parameter int COORD_WIDTH = 32,
    parameter int FRAC_BITS   = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    rri_ray_if.sink                ray,
    rri_hit_if.source              result,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0] cfg_data
);

    localparam int W     = COORD_WIDTH;
    localparam int NUM_W = (2*W-1 > W+FRAC_BITS) ? 2*W-1 : W+FRAC_BITS;
    localparam int Q_W   = $bits(rri_flags_t) + 3*W + 3*NUM_W + 2*(W-1);
    localparam logic [W-1:0] ONE_Q     = W'(1) << FRAC_BITS;
    localparam logic [W-1:0] NEG_ONE_Q = ~ONE_Q + W'(1);

    // rectangle registers
    logic [W-1:0] x_min_reg, x_max_reg, z_min_reg, z_max_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_min_reg <= NEG_ONE_Q;
            x_max_reg <= ONE_Q;
            z_min_reg <= NEG_ONE_Q;
            z_max_reg <= ONE_Q;
        end
        else if (cfg_we)
        begin
            unique case (rri_cfg_idx_t'(cfg_index))
                CFG_X_MIN: x_min_reg <= cfg_data;
                CFG_X_MAX: x_max_reg <= cfg_data;
                CFG_Z_MIN: z_min_reg <= cfg_data;
                CFG_Z_MAX: z_max_reg <= cfg_data;
            endcase
        end
    end

    // front end
    logic             f_valid, f_ready;
    rri_flags_t       f_flags;
    logic [W-1:0]     f_dy, f_ox, f_oz;
    logic [NUM_W-1:0] f_nt, f_nx, f_nz;
    logic [W-2:0]     f_tl, f_tu;

    rri_front #(
        .W     (W),
        .F     (FRAC_BITS),
        .NUM_W (NUM_W)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .ray     (ray),
        .q_valid (f_valid),
        .q_ready (f_ready),
        .flags   (f_flags),
        .dy_mag  (f_dy),
        .num_t   (f_nt),
        .num_x   (f_nx),
        .num_z   (f_nz),
        .ox      (f_ox),
        .oz      (f_oz),
        .tl      (f_tl),
        .tu      (f_tu)
    );

    // decoupling queue
    logic             b_valid, b_ready;
    logic [Q_W-1:0]   q_in, q_out;
    rri_flags_t       b_flags;
    logic [W-1:0]     b_dy, b_ox, b_oz;
    logic [NUM_W-1:0] b_nt, b_nx, b_nz;
    logic [W-2:0]     b_tl, b_tu;

    assign q_in = {f_flags, f_dy, f_nt, f_nx, f_nz, f_ox, f_oz, f_tl, f_tu};
    assign {b_flags, b_dy, b_nt, b_nx, b_nz, b_ox, b_oz, b_tl, b_tu} = q_out;

    rri_queue #(
        .DATA_W (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (q_in),
        .out_valid (b_valid),
        .out_ready (b_ready),
        .out_data  (q_out)
    );

    // back end
    rri_back #(
        .W     (W),
        .NUM_W (NUM_W)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (b_valid),
        .q_ready (b_ready),
        .flags   (b_flags),
        .dy_mag  (b_dy),
        .num_t   (b_nt),
        .num_x   (b_nx),
        .num_z   (b_nz),
        .ox      (b_ox),
        .oz      (b_oz),
        .tl      (b_tl),
        .tu      (b_tu),
        .x_min   (x_min_reg),
        .x_max   (x_max_reg),
        .z_min   (z_min_reg),
        .z_max   (z_max_reg),
        .result  (result)
    );

endmodule

// ===== rtl/rri_checker.sv =====
// port-level checks on the result channel of ray_rect_intersect_unit, bound to the top
// depends on rri_pkg and ray_rect_intersect_unit_macros.svh
`include "ray_rect_intersect_unit_macros.svh"

module rri_checker import rri_pkg::*; #(
    parameter int COORD_WIDTH = 32
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic                   hit,
    input logic [COORD_WIDTH-1:0] t_hit,
    input logic [UV_BITS-1:0]     u_coord,
    input logic [UV_BITS-1:0]     v_coord,
    input logic [COORD_WIDTH-1:0] point_x,
    input logic [COORD_WIDTH-1:0] point_y,
    input logic [COORD_WIDTH-1:0] point_z,
    input logic                   front_face
);

    // a stalled result stays offered
    `RRI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")

    // a stalled result keeps its hit flag, t_hit, point_x and point_z
    `RRI_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(hit) && $stable(t_hit) && $stable(point_x) && $stable(point_z), "result changed while stalled")

    // a miss carries an all-zero payload
    `RRI_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid && !hit, t_hit == '0 && u_coord == '0 && v_coord == '0 && point_x == '0 && point_z == '0 && !front_face, "miss with nonzero fields")

    // the hit point lies on the y = 0 plane
    `RRI_ASSERT_NOW(a_point_y_zero, clk, rst_n, out_valid, point_y == '0, "point_y not zero")

endmodule

bind ray_rect_intersect_unit rri_checker #(.COORD_WIDTH(COORD_WIDTH)) u_rri_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .hit        (result.hit),
    .t_hit      (result.t_hit),
    .u_coord    (result.u_coord),
    .v_coord    (result.v_coord),
    .point_x    (result.point_x),
    .point_y    (result.point_y),
    .point_z    (result.point_z),
    .front_face (result.front_face)
);

// ===== tb/testbench.sv =====
// self-checking bench for ray_rect_intersect_unit: random and directed rays
// depends on rri_pkg, rri_ray_if, rri_hit_if and the block itself
module testbench;
    import rri_pkg::*;

    localparam int CW        = 32;
    localparam int CYC_LIMIT = 600000;
    localparam int DRAIN     = 160;
    localparam int N_RANDOM  = 2000;
    localparam int N_PHASES  = 5;

    typedef struct {
        logic signed [CW-1:0] origin_x, origin_y, origin_z;
        logic signed [CW-1:0] dir_x, dir_y, dir_z;
        logic [CW-2:0]        t_lower, t_upper;
    } ray_t;

    typedef struct {
        logic                 hit;
        logic signed [CW-1:0] t_hit;
        logic [UV_BITS-1:0]   u_coord, v_coord;
        logic signed [CW-1:0] point_x, point_y, point_z;
        logic                 front_face;
    } hit_t;

    // expected hits and the rectangle the block should be using
    class hit_scoreboard;
        hit_t    pending_hits[$];
        longint  x_min, x_max, z_min, z_max;
        int      mismatches;
        int      rays_seen;
        int      hits_seen;
        int      results_seen;

        function void set_rect(rri_cfg_idx_t idx, logic signed [CW-1:0] val);
            case (idx)
                CFG_X_MIN: x_min = longint'(val);
                CFG_X_MAX: x_max = longint'(val);
                CFG_Z_MIN: z_min = longint'(val);
                default:   z_max = longint'(val);
            endcase
        endfunction

        // position inside [lo, hi] scaled to Q0.16, clamped
        function logic [UV_BITS-1:0] normalize(longint p, longint lo, longint hi);
            longint span;
            longint q;
            span = hi - lo;
            if (span <= 0)
                return '0;
            q = ((p - lo) * 65536) / span;
            if (q < 0)
                q = 0;
            if (q > 65535)
                q = 65535;
            return q[UV_BITS-1:0];
        endfunction

        function hit_t intersect_ray(ray_t r);
            hit_t   h;
            longint ox, oy, oz, dx, dy, dz, tl, tu, t, x, z;
            h = '{default: '0};
            ox = longint'(r.origin_x); oy = longint'(r.origin_y); oz = longint'(r.origin_z);
            dx = longint'(r.dir_x);    dy = longint'(r.dir_y);    dz = longint'(r.dir_z);
            tl = longint'(r.t_lower);  tu = longint'(r.t_upper);
            if (dy == 0)
                return h;
            t = (-oy * 65536) / dy;
            if (t < tl)
                return h;
            if (r.t_upper != '1 && t > tu)
                return h;
            x = ox + (-oy * dx) / dy;
            z = oz + (-oy * dz) / dy;
            if (x < x_min || x > x_max || z < z_min || z > z_max)
                return h;
            h.hit = 1'b1;
            if (t > 64'sh7fffffff)
                t = 64'sh7fffffff;
            h.t_hit      = t[CW-1:0];
            h.u_coord    = normalize(x, x_min, x_max);
            h.v_coord    = normalize(z, z_min, z_max);
            h.point_x    = x[CW-1:0];
            h.point_z    = z[CW-1:0];
            h.front_face = (dy < 0);
            return h;
        endfunction

        function void note_ray(ray_t r);
            hit_t h;
            h = intersect_ray(r);
            pending_hits.push_back(h);
            rays_seen++;
            if (h.hit)
                hits_seen++;
        endfunction

        function void field(string name, longint exp_v, longint act_v, ref bit bad);
            if (exp_v != act_v) begin
                bad = 1;
                if (mismatches < 10)
                    $display("  %s: expected %0d, got %0d", name, exp_v, act_v);
            end
        endfunction

        function void check_result(hit_t a);
            hit_t e;
            bit   bad;
            results_seen++;
            if (pending_hits.size() == 0) begin
                if (mismatches < 10)
                    $display("result with no request outstanding");
                mismatches++;
                return;
            end
            e = pending_hits.pop_front();
            bad = 0;
            if (mismatches < 10 && e != a)
                $display("mismatch on result %0d:", results_seen);
            field("hit",        e.hit,        a.hit,        bad);
            field("t_hit",      e.t_hit,      a.t_hit,      bad);
            field("u_coord",    e.u_coord,    a.u_coord,    bad);
            field("v_coord",    e.v_coord,    a.v_coord,    bad);
            field("point_x",    e.point_x,    a.point_x,    bad);
            field("point_y",    e.point_y,    a.point_y,    bad);
            field("point_z",    e.point_z,    a.point_z,    bad);
            field("front_face", e.front_face, a.front_face, bad);
            if (bad)
                mismatches++;
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CW-1:0]        cfg_data;

    rri_ray_if #(.COORD_WIDTH(CW)) ray_ch ();
    rri_hit_if #(.COORD_WIDTH(CW)) hit_ch ();

    ray_rect_intersect_unit #(.COORD_WIDTH(CW), .FRAC_BITS(16)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .ray       (ray_ch),
        .result    (hit_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    hit_scoreboard sb;
    bit     no_idle;
    bit     hold_req;
    int     cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycles,
                     sb.pending_hits.size());
            $display("testbench: errors");
            $finish;
        end
    end

    // observe both channels
    always @(posedge clk)
    begin
        ray_t r;
        hit_t h;
        if (rst_n) begin
            if (ray_ch.valid && ray_ch.ready) begin
                r.origin_x = ray_ch.origin_x; r.origin_y = ray_ch.origin_y;
                r.origin_z = ray_ch.origin_z;
                r.dir_x = ray_ch.dir_x; r.dir_y = ray_ch.dir_y; r.dir_z = ray_ch.dir_z;
                r.t_lower = ray_ch.t_lower; r.t_upper = ray_ch.t_upper;
                sb.note_ray(r);
            end
            if (hit_ch.valid && hit_ch.ready) begin
                h.hit = hit_ch.hit; h.t_hit = hit_ch.t_hit;
                h.u_coord = hit_ch.u_coord; h.v_coord = hit_ch.v_coord;
                h.point_x = hit_ch.point_x; h.point_y = hit_ch.point_y;
                h.point_z = hit_ch.point_z; h.front_face = hit_ch.front_face;
                sb.check_result(h);
            end
        end
    end

    // result side: random stalls, one long hold-off on request
    initial
    begin
        int held;
        hit_ch.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req) begin
                hit_ch.ready <= 1'b0;
                for (held = 0; held < 500; held++)
                    @(posedge clk);
                hold_req = 0;
            end
            hit_ch.ready <= no_idle || ($urandom_range(0, 99) >= 33);
        end
    end

    task automatic send_ray(ray_t r);
        while (!no_idle && $urandom_range(0, 99) < 33) begin
            ray_ch.valid <= 1'b0;
            @(posedge clk);
        end
        ray_ch.valid    <= 1'b1;
        ray_ch.origin_x <= r.origin_x; ray_ch.origin_y <= r.origin_y;
        ray_ch.origin_z <= r.origin_z;
        ray_ch.dir_x <= r.dir_x; ray_ch.dir_y <= r.dir_y; ray_ch.dir_z <= r.dir_z;
        ray_ch.t_lower <= r.t_lower; ray_ch.t_upper <= r.t_upper;
        do
            @(posedge clk);
        while (!(ray_ch.valid && ray_ch.ready));
    endtask

    task automatic write_rect(rri_cfg_idx_t idx, logic signed [CW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        sb.set_rect(idx, val);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_rect_all(logic signed [CW-1:0] xl, xh, zl, zh);
        write_rect(CFG_X_MIN, xl);
        write_rect(CFG_X_MAX, xh);
        write_rect(CFG_Z_MIN, zl);
        write_rect(CFG_Z_MAX, zh);
    endtask

    // wait for every result plus the pipeline depth
    task automatic drain();
        int n;
        ray_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_hits.size() != 0)
            @(posedge clk);
        for (n = 0; n < DRAIN; n++)
            @(posedge clk);
    endtask

    function automatic int span(int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    function automatic ray_t mk_ray(int ox, oy, oz, dx, dy, dz, tl, tu);
        ray_t r;
        r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
        r.dir_x = dx; r.dir_y = dy; r.dir_z = dz;
        r.t_lower = tl[CW-2:0]; r.t_upper = tu[CW-2:0];
        return r;
    endfunction

    // mostly rays aimed near the rectangle, some pure noise
    function automatic ray_t random_ray(int scale);
        ray_t r;
        int   dy;
        if ($urandom_range(0, 99) < 30) begin
            r = mk_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom);
            if ($urandom_range(0, 3) == 0)
                r.t_upper = '1;
            return r;
        end
        dy = $urandom_range(1, 4 << 16);
        if ($urandom_range(0, 1))
            dy = -dy;
        if ($urandom_range(0, 19) == 0)
            dy = 0;
        r = mk_ray(span(3 * scale), span(8 << 16), span(3 * scale), span(2 * scale), dy,
                   span(2 * scale), 0, '1);
        if ($urandom_range(0, 3) == 0)
            r.t_lower = (CW-1)'($urandom_range(0, 4 << 16));
        if ($urandom_range(0, 3) == 0)
            r.t_upper = (CW-1)'($urandom_range(0, 16 << 16));
        return r;
    endfunction

    localparam int ONE  = 1 << 16;
    localparam int SMAX = 32'h7fffffff;
    localparam int SMIN = 32'h80000000;

    initial
    begin
        int phase;
        int k;
        int scale;
        sb = new();
        sb.x_min = -ONE; sb.x_max = ONE; sb.z_min = -ONE; sb.z_max = ONE;
        cycles = 0;
        no_idle = 0;
        hold_req = 0;
        rst_n = 1'b0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        ray_ch.valid = 1'b0;
        ray_ch.origin_x = '0; ray_ch.origin_y = '0; ray_ch.origin_z = '0;
        ray_ch.dir_x = '0; ray_ch.dir_y = '0; ray_ch.dir_z = '0;
        ray_ch.t_lower = '0; ray_ch.t_upper = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rays against the reset rectangle
        send_ray(mk_ray(0, ONE, 0, 0, -ONE, 0, 0, '1));              // straight down, center
        send_ray(mk_ray(0, -ONE, 0, 0, ONE, 0, 0, '1));              // from below, back face
        send_ray(mk_ray(0, ONE, 0, 0, 0, 0, 0, '1));                 // parallel to plane
        send_ray(mk_ray(ONE, ONE, ONE, 0, -ONE, 0, 0, '1));          // corner, inclusive
        send_ray(mk_ray(-ONE, ONE, -ONE, 0, -ONE, 0, 0, '1));        // opposite corner
        send_ray(mk_ray(ONE + 1, ONE, 0, 0, -ONE, 0, 0, '1));        // just outside x
        send_ray(mk_ray(0, ONE, -ONE - 1, 0, -ONE, 0, 0, '1));       // just outside z
        send_ray(mk_ray(0, ONE, 0, 0, -ONE, 0, ONE + 1, '1));        // t below lower
        send_ray(mk_ray(0, ONE, 0, 0, -ONE, 0, ONE, ONE));           // t on both limits
        send_ray(mk_ray(0, 2 * ONE, 0, 0, -ONE, 0, 0, ONE));         // t above upper
        send_ray(mk_ray(0, ONE, 0, 0, ONE, 0, 0, '1));               // plane behind ray
        send_ray(mk_ray(0, SMIN, 0, 0, 1, 0, 0, '1));                // t saturates
        send_ray(mk_ray(0, SMAX, 0, 0, SMIN, 0, 0, '1));             // extreme negative dy
        send_ray(mk_ray(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX));
        send_ray(mk_ray(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, 0, 0));
        send_ray(mk_ray(-1, -1, -1, -1, -1, -1, '1, '1));
        send_ray(mk_ray(0, 0, 0, 0, -ONE, 0, 0, 0));                 // origin on plane
        send_ray(mk_ray(-ONE, ONE, 0, 2 * ONE, -ONE, ONE, 0, '1));   // slanted to far edge
        send_ray(mk_ray(ONE / 2, ONE, -ONE / 2, 0, -ONE, 0, 0, '1)); // inside, u and v mid

        for (phase = 0; phase < N_PHASES; phase++) begin
            drain();
            scale = ONE;
            case (phase)
                0: ;
                1: set_rect_all(-4 * ONE, 4 * ONE, -3 * ONE, 5 * ONE);
                2: begin
                    set_rect_all(SMIN, SMAX, SMIN, SMAX);
                    scale = 64 * ONE;
                end
                3: set_rect_all(0, 0, -ONE, ONE);                   // zero-width in x
                default: set_rect_all(-2 * ONE, 2 * ONE, ONE, -ONE); // z bounds swapped
            endcase
            for (k = 0; k < N_RANDOM / N_PHASES; k++) begin
                no_idle  = (phase == 1 && k >= 100 && k < 250);
                if (phase == 2 && k == 50)
                    hold_req = 1;
                send_ray(random_ray(scale));
            end
            no_idle = 0;
        end
        drain();

        $display("covered %0d rays, %0d hits, 5 rectangle settings incl. full range,",
                 sb.rays_seen, sb.hits_seen);
        $display("zero width and swapped bounds; %0d results checked, %0d mismatches",
                 sb.results_seen, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending_hits.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rri_pkg.sv
rtl/rri_stream_if.sv
rtl/rri_div_pipe.sv
rtl/rri_queue.sv
rtl/rri_front.sv
rtl/rri_back.sv
rtl/ray_rect_intersect_unit.sv
rtl/rri_checker.sv
tb/testbench.sv
